// ===== src/ppsa_pkg.sv =====
// Shared constants, widths and the arctangent table of the pure pursuit steering block.
// Used by the CORDIC cells and by the top level.
`default_nettype none
package ppsa_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int IDX_W = 5;
	localparam int ANG_W = 29;
	localparam int SIN_W = 33;
	localparam int VEC_W = 48;
	localparam int LD_W = 14;
	localparam int ANGLE_FRAC = 12;
	localparam logic signed [SIN_W-1:0] CORDIC_K = 33'sd652032875;

	localparam logic [2:0] REG_WHEELBASE = 3'd0;
	localparam logic [2:0] REG_OFFSET = 3'd1;
	localparam logic [2:0] REG_MIN_LA = 3'd2;
	localparam logic [2:0] REG_MAX_LA = 3'd3;
	localparam logic [2:0] REG_MAX_STEER = 3'd4;

	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			5'd0: v = 29'sd18432000;
			5'd1: v = 29'sd10881045;
			5'd2: v = 29'sd5749245;
			5'd3: v = 29'sd2918407;
			5'd4: v = 29'sd1464867;
			5'd5: v = 29'sd733147;
			5'd6: v = 29'sd366663;
			5'd7: v = 29'sd183343;
			5'd8: v = 29'sd91673;
			5'd9: v = 29'sd45837;
			5'd10: v = 29'sd22918;
			5'd11: v = 29'sd11459;
			5'd12: v = 29'sd5730;
			5'd13: v = 29'sd2865;
			5'd14: v = 29'sd1432;
			5'd15: v = 29'sd716;
			5'd16: v = 29'sd358;
			5'd17: v = 29'sd179;
			5'd18: v = 29'sd90;
			5'd19: v = 29'sd45;
			5'd20: v = 29'sd22;
			5'd21: v = 29'sd11;
			5'd22: v = 29'sd6;
			5'd23: v = 29'sd3;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== src/pure_pursuit_steering_angle.sv =====
// Top level of the pure pursuit steering block: input stage, sine and arctangent chains.
// Depends on ppsa_pkg, ppsa_rot_cell and ppsa_vec_cell.
`default_nettype none
// The block turns a target bearing and range into a steering angle, one beat per clock.
// A beat passes an input stage, CORDIC_STAGES sine cells, a multiply stage,
// CORDIC_STAGES arctangent cells and an output register; the whole pipeline holds when
// the output register is full and not taken. Configuration writes are always ready.
module pure_pursuit_steering_angle import ppsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [13:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [15:0] target_bearing,
	input wire logic [13:0] target_range_mm,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [14:0] steer_angle
);
	logic [9:0] wheelbase_q;
	logic [11:0] offset_q;
	logic [13:0] min_la_q, max_la_q, max_steer_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= 10'd150;
			offset_q <= 12'd100;
			min_la_q <= 14'd100;
			max_la_q <= 14'd1500;
			max_steer_q <= 14'd3000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WHEELBASE: wheelbase_q <= cfg_data[9:0];
				REG_OFFSET: offset_q <= cfg_data[11:0];
				REG_MIN_LA: min_la_q <= cfg_data;
				REG_MAX_LA: max_la_q <= cfg_data;
				REG_MAX_STEER: max_steer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [16:0] b_ext, b_wrap, b_fold;
	logic signed [15:0] d_ld;
	logic [LD_W-1:0] ld;

	always_comb begin
		b_ext = 17'(target_bearing);
		if (b_ext >= 17'sd18000) begin
			b_wrap = b_ext - 17'sd36000;
		end else if (b_ext < -17'sd18000) begin
			b_wrap = b_ext + 17'sd36000;
		end else begin
			b_wrap = b_ext;
		end
		if (b_wrap > 17'sd9000) begin
			b_fold = 17'sd18000 - b_wrap;
		end else if (b_wrap < -17'sd9000) begin
			b_fold = -17'sd18000 - b_wrap;
		end else begin
			b_fold = b_wrap;
		end
		d_ld = $signed({2'b00, target_range_mm}) - $signed({4'b0000, offset_q});
		if (d_ld < $signed({2'b00, min_la_q})) begin
			ld = min_la_q;
		end else if (d_ld > $signed({2'b00, max_la_q})) begin
			ld = max_la_q;
		end else begin
			ld = d_ld[LD_W-1:0];
		end
	end

	logic valid_s1;
	logic signed [ANG_W-1:0] z_s1;
	logic [LD_W-1:0] ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= ANG_W'(b_fold) <<< ANGLE_FRAC;
			ld_s1 <= ld;
		end
	end

	logic rv [CORDIC_STAGES+1];
	logic signed [SIN_W-1:0] rx [CORDIC_STAGES+1];
	logic signed [SIN_W-1:0] ry [CORDIC_STAGES+1];
	logic signed [ANG_W-1:0] rz [CORDIC_STAGES+1];
	logic [LD_W-1:0] rl [CORDIC_STAGES+1];

	assign rv[0] = valid_s1;
	assign rx[0] = CORDIC_K;
	assign ry[0] = '0;
	assign rz[0] = z_s1;
	assign rl[0] = ld_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		ppsa_rot_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .idx(IDX_W'(i)),
			.valid_i(rv[i]), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]), .ld_i(rl[i]),
			.valid_q(rv[i+1]), .x_q(rx[i+1]), .y_q(ry[i+1]), .z_q(rz[i+1]),
			.ld_q(rl[i+1])
		);
	end

	logic signed [SIN_W+10:0] prod;
	logic valid_s2, zero_s2;
	logic signed [VEC_W-1:0] num_s2, den_s2;

	assign prod = $signed({1'b0, wheelbase_q}) * ry[CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= rv[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= VEC_W'(prod) <<< 1;
			zero_s2 <= (prod == '0);
			den_s2 <= $signed({4'b0000, rl[CORDIC_STAGES], 30'b0});
		end
	end

	logic vv [CORDIC_STAGES+1];
	logic signed [VEC_W-1:0] vx [CORDIC_STAGES+1];
	logic signed [VEC_W-1:0] vy [CORDIC_STAGES+1];
	logic signed [ANG_W-1:0] vz [CORDIC_STAGES+1];
	logic vzero [CORDIC_STAGES+1];

	assign vv[0] = valid_s2;
	assign vx[0] = den_s2;
	assign vy[0] = num_s2;
	assign vz[0] = '0;
	assign vzero[0] = zero_s2;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		ppsa_vec_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .idx(IDX_W'(i)),
			.valid_i(vv[i]), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]), .zero_i(vzero[i]),
			.valid_q(vv[i+1]), .x_q(vx[i+1]), .y_q(vy[i+1]), .z_q(vz[i+1]),
			.zero_q(vzero[i+1])
		);
	end

	logic signed [ANG_W:0] z_rnd;
	logic signed [ANG_W-ANGLE_FRAC:0] steer;
	logic signed [ANG_W-ANGLE_FRAC:0] lim;
	logic signed [ANG_W-ANGLE_FRAC:0] steer_sat;

	always_comb begin
		z_rnd = vzero[CORDIC_STAGES] ? '0
			: (ANG_W+1)'(vz[CORDIC_STAGES]) + (ANG_W+1)'(2048);
		steer = z_rnd[ANG_W:ANGLE_FRAC];
		lim = $signed({4'b0000, max_steer_q});
		if (steer > lim) begin
			steer_sat = lim;
		end else if (steer < -lim) begin
			steer_sat = -lim;
		end else begin
			steer_sat = steer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vv[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steer_angle <= steer_sat[14:0];
		end
	end
endmodule
`default_nettype wire

// ===== src/ppsa_rot_cell.sv =====
// One rotation-mode CORDIC cell of the sine chain; carries the lookahead alongside.
// Depends on ppsa_pkg for widths and the arctangent table.
`default_nettype none
module ppsa_rot_cell import ppsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [IDX_W-1:0] idx,
	input wire logic valid_i,
	input wire logic signed [SIN_W-1:0] x_i,
	input wire logic signed [SIN_W-1:0] y_i,
	input wire logic signed [ANG_W-1:0] z_i,
	input wire logic [LD_W-1:0] ld_i,
	output logic valid_q,
	output logic signed [SIN_W-1:0] x_q,
	output logic signed [SIN_W-1:0] y_q,
	output logic signed [ANG_W-1:0] z_q,
	output logic [LD_W-1:0] ld_q
);
	logic signed [SIN_W-1:0] dx, dy;
	logic signed [ANG_W-1:0] a;

	assign dx = y_i >>> idx;
	assign dy = x_i >>> idx;
	assign a = atan_lut(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_q <= ld_i;
			if (!z_i[ANG_W-1]) begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - a;
			end else begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + a;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/ppsa_vec_cell.sv =====
// One vectoring-mode CORDIC cell of the arctangent chain; carries the zero-numerator flag.
// Depends on ppsa_pkg for widths and the arctangent table.
`default_nettype none
module ppsa_vec_cell import ppsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [IDX_W-1:0] idx,
	input wire logic valid_i,
	input wire logic signed [VEC_W-1:0] x_i,
	input wire logic signed [VEC_W-1:0] y_i,
	input wire logic signed [ANG_W-1:0] z_i,
	input wire logic zero_i,
	output logic valid_q,
	output logic signed [VEC_W-1:0] x_q,
	output logic signed [VEC_W-1:0] y_q,
	output logic signed [ANG_W-1:0] z_q,
	output logic zero_q
);
	logic signed [VEC_W-1:0] dx, dy;
	logic signed [ANG_W-1:0] a;

	assign dx = y_i >>> idx;
	assign dy = x_i >>> idx;
	assign a = atan_lut(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero_i;
			if (!y_i[VEC_W-1]) begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + a;
			end else begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - a;
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_pure_pursuit_steering_angle.sv =====
// Self-checking testbench for pure_pursuit_steering_angle: directed and random beats,
// checked against typed values or a bit-exact CORDIC steering predictor, under bursty traffic and stalls.
// Depends on ppsa_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_pure_pursuit_steering_angle;
	import ppsa_pkg::*;

	typedef struct {
		logic signed [15:0] bearing;
		logic [13:0] range_mm;
		bit typed;
		logic signed [14:0] steer;
	} steer_row_t;

	localparam longint ATAN_UNITS [24] = '{
		18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
		91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
		358, 179, 90, 45, 22, 11, 6, 3
	};

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [13:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] target_bearing;
	logic [13:0] target_range_mm;
	logic out_valid;
	logic out_ready;
	logic signed [14:0] steer_angle;

	logic [9:0] wb_mm;
	logic [11:0] offset_mm;
	logic [13:0] min_la_mm;
	logic [13:0] max_la_mm;
	logic [13:0] steer_limit;

	logic signed [14:0] steer_expect[$];
	steer_row_t dir_rows[$];
	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int hold_cnt = 0;
	bit hold_done = 0;
	bit bursty = 1;

	pure_pursuit_steering_angle DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.target_bearing(target_bearing), .target_range_mm(target_range_mm),
		.out_valid(out_valid), .out_ready(out_ready),
		.steer_angle(steer_angle)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint sine_q30(longint z);
		longint x;
		longint y;
		longint dx;
		longint dy;
		x = 652032875;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_UNITS[i];
			end else begin
				x += dx; y -= dy; z += ATAN_UNITS[i];
			end
		end
		return y;
	endfunction

	function automatic longint arctan2_units(longint y, longint x);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		if (y == 0)
			return 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_UNITS[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_UNITS[i];
			end
		end
		return z;
	endfunction

	function automatic logic signed [14:0] predict_steer(logic signed [15:0] b_in,
			logic [13:0] r_in);
		int b;
		int la;
		longint s;
		longint z;
		longint st;
		longint lim;
		b = b_in;
		while (b >= 18000) b -= 36000;
		while (b < -18000) b += 36000;
		if (b > 9000)
			b = 18000 - b;
		else if (b < -9000)
			b = -18000 - b;
		la = int'(r_in) - int'(offset_mm);
		if (la < int'(min_la_mm))
			la = min_la_mm;
		else if (la > int'(max_la_mm))
			la = max_la_mm;
		s = sine_q30(longint'(b) <<< ANGLE_FRAC);
		z = arctan2_units(2 * longint'(wb_mm) * s, longint'(la) <<< 30);
		st = (z + 2048) >>> ANGLE_FRAC;
		lim = steer_limit;
		if (st > lim)
			st = lim;
		else if (st < -lim)
			st = -lim;
		return st[14:0];
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [13:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WHEELBASE: wb_mm = data[9:0];
			REG_OFFSET: offset_mm = data[11:0];
			REG_MIN_LA: min_la_mm = data;
			REG_MAX_LA: max_la_mm = data;
			REG_MAX_STEER: steer_limit = data;
			default: ;
		endcase
	endtask

	task automatic configure(logic [13:0] wb, logic [13:0] off, logic [13:0] mn,
			logic [13:0] mx, logic [13:0] lim);
		write_reg(REG_WHEELBASE, wb);
		write_reg(REG_OFFSET, off);
		write_reg(REG_MIN_LA, mn);
		write_reg(REG_MAX_LA, mx);
		write_reg(REG_MAX_STEER, lim);
		write_reg(3'(5 + $urandom_range(0, 2)), 14'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_beat(logic signed [15:0] b, logic [13:0] r, bit typed,
			logic signed [14:0] typed_steer);
		int gap;
		in_valid <= 1'b1;
		target_bearing <= b;
		target_range_mm <= r;
		do @(posedge clk); while (!in_ready);
		steer_expect.push_back(typed ? typed_steer : predict_steer(b, r));
		beats_in++;
		if (bursty) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 20);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else
				burst_left--;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (steer_expect.size() != 0) @(posedge clk);
		repeat (2 * CORDIC_STAGES + 8) @(posedge clk);
	endtask

	task automatic random_beats(int n);
		logic signed [15:0] b;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				b = 16'($urandom_range(0, 36000) - 18000);
			else if (pick < 92)
				b = 16'($urandom);
			else
				b = 16'(9000 * ($urandom_range(0, 4) - 2) + $urandom_range(0, 4) - 2);
			send_beat(b, 14'($urandom), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			beats_out++;
			if (steer_expect.size() == 0) begin
				$error("steer_angle: unexpected beat, actual %0d", steer_angle);
				mismatches++;
			end else if (steer_angle !== steer_expect[0]) begin
				$error("steer_angle: expected %0d, actual %0d", steer_expect[0], steer_angle);
				mismatches++;
				void'(steer_expect.pop_front());
			end else
				void'(steer_expect.pop_front());
		end
		if (!hold_done && beats_out == 400) begin
			hold_done <= 1'b1;
			hold_cnt <= 300;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				default: out_ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		target_bearing = '0;
		target_range_mm = '0;
		out_ready = 1'b0;
		wb_mm = 150;
		offset_mm = 100;
		min_la_mm = 100;
		max_la_mm = 1500;
		steer_limit = 3000;

		dir_rows.push_back('{16'sd0, 14'd500, 1, 15'sd0});
		dir_rows.push_back('{16'sd9000, 14'd200, 1, 15'sd3000});
		dir_rows.push_back('{-16'sd9000, 14'd200, 1, -15'sd3000});
		dir_rows.push_back('{16'sd18000, 14'd800, 0, '0});
		dir_rows.push_back('{-16'sd18000, 14'd800, 0, '0});
		dir_rows.push_back('{16'sd17999, 14'd800, 0, '0});
		dir_rows.push_back('{-16'sd17999, 14'd800, 0, '0});
		dir_rows.push_back('{16'sd9001, 14'd1000, 0, '0});
		dir_rows.push_back('{-16'sd9001, 14'd1000, 0, '0});
		dir_rows.push_back('{16'sd32767, 14'd900, 0, '0});
		dir_rows.push_back('{-16'sd32768, 14'd900, 0, '0});
		dir_rows.push_back('{16'sd27000, 14'd700, 0, '0});
		dir_rows.push_back('{-16'sd27000, 14'd700, 0, '0});
		dir_rows.push_back('{16'sd4500, 14'd0, 0, '0});
		dir_rows.push_back('{16'sd4500, 14'd16383, 0, '0});
		dir_rows.push_back('{16'sd4500, 14'd200, 0, '0});
		dir_rows.push_back('{-16'sd4500, 14'd1600, 0, '0});
		dir_rows.push_back('{16'sd1, 14'd1600, 0, '0});
		dir_rows.push_back('{-16'sd1, 14'd1600, 0, '0});
		dir_rows.push_back('{16'sd300, 14'd16383, 0, '0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rx_mode = 0;
		foreach (dir_rows[i])
			send_beat(dir_rows[i].bearing, dir_rows[i].range_mm, dir_rows[i].typed,
				dir_rows[i].steer);
		drain();

		// Each phase: idle, reprogram, stream random beats with a traffic shape set by its index.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: configure(14'd1023, 14'd4095, 14'd1, 14'd16383, 14'd9000);
				1: configure(14'd500, 14'd0, 14'd5000, 14'd300, 14'd0);
				2: configure(14'd1, 14'd0, 14'd0, 14'd16383, 14'd9000);
				3: configure(14'h3C00, 14'd50, 14'd0, 14'd0, 14'd4500);
				default: configure(14'($urandom), 14'($urandom), 14'($urandom_range(0, 16383)),
					14'($urandom_range(0, 16383)), 14'($urandom_range(0, 9000)));
			endcase
			rx_mode = ph % 3;
			bursty = (ph != 4);
			random_beats(ph == 3 ? 150 : 95);
			drain();
		end

		$display("Covered %0d input beats and %0d results over 8 register settings,",
			beats_in, beats_out);
		$display("with wrapped and folded bearings, lookahead clamps and steering limits.");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
